// File: rtl/core/acet_pkg.sv
// ----------------------------------------------------------------------------
// acet_pkg
// shared types and constants of the box contact event tracker
// ----------------------------------------------------------------------------
package acet_pkg;

    // number of collider ids; one contact bit per ordered pair of ids
    localparam int NUM_COLLIDERS = 64;
    localparam int PAIR_DEPTH    = NUM_COLLIDERS * NUM_COLLIDERS;
    localparam int IDX_W         = $clog2(PAIR_DEPTH);

    localparam int ID_W    = 6;
    localparam int COORD_W = 16;
    localparam int DEPTH_W = 17;
    localparam int EV_W    = 2;

    // contact event codes
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_ENTER = 2'd1;
    localparam logic [EV_W-1:0] EV_STAY  = 2'd2;
    localparam logic [EV_W-1:0] EV_EXIT  = 2'd3;

    // write request into the contact table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             data;
    } acet_wr_t;

endpackage

// File: rtl/core/acet_axis.sv
// ----------------------------------------------------------------------------
// acet_axis
// one-axis overlap test: registers doubled centre distance and size sum,
// then compares and gives the doubled depth
// ----------------------------------------------------------------------------
module acet_axis
    import acet_pkg::*;
(
    input  logic                      clk,
    input  logic                      load,
    input  logic signed [COORD_W-1:0] lc,
    input  logic        [COORD_W-1:0] ls,
    input  logic signed [COORD_W-1:0] rc,
    input  logic        [COORD_W-1:0] rs,
    output logic                      hit,
    output logic        [DEPTH_W-1:0] depth
);

    logic signed [COORD_W:0]   diff;
    logic        [COORD_W:0]   abs_diff;
    logic        [COORD_W+1:0] twice_reg;
    logic        [COORD_W+1:0] twice_next;
    logic        [COORD_W:0]   sum_reg;
    logic        [COORD_W:0]   sum_next;
    logic        [COORD_W+1:0] gap;

    // first half: distance and size sum
    always_comb
    begin
        diff       = {rc[COORD_W-1], rc} - {lc[COORD_W-1], lc};
        abs_diff   = diff[COORD_W] ? $unsigned(-diff) : $unsigned(diff);
        twice_next = {abs_diff, 1'b0};
        sum_next   = {1'b0, ls} + {1'b0, rs};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            twice_reg <= twice_next;
            sum_reg   <= sum_next;
        end
    end

    // second half: strict compare, touching edges are no overlap
    always_comb
    begin
        gap   = {1'b0, sum_reg} - twice_reg;
        hit   = {1'b0, sum_reg} > twice_reg;
        depth = hit ? gap[DEPTH_W-1:0] : '0;
    end

endmodule

// File: rtl/core/acet_pair_mem.sv
// ----------------------------------------------------------------------------
// acet_pair_mem
// contact bit table, one bit per ordered pair, with a clearing pass
// ----------------------------------------------------------------------------
module acet_pair_mem
    import acet_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data,
    input  acet_wr_t         wr,
    output logic             ready
);

    logic             mem [0:PAIR_DEPTH-1];
    logic             rd_data_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic             clr_busy_reg;
    logic             clr_busy_next;

    // sweep every entry to zero after reset
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(PAIR_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

// File: rtl/core/aabb_contact_event_tracker_core.sv
// ----------------------------------------------------------------------------
// aabb_contact_event_tracker_core
// box pair overlap test with enter, stay and exit tracking per ordered pair
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one collider pair per item: ids and box centres and sizes
//   in tdata, the two active flags in tuser. m_axis returns one result per
//   item: the contact event in tuser, the doubled overlap depths in tdata.
//   the table stage registers an item when taken, then the output register.
//   throughput: one item per cycle while m_axis_tready is high. the contact
//   table is a synchronous ram read when the item is taken and written back
//   when it leaves the table stage; a write and a read of the same pair on
//   one edge are bridged by a forward path. reset: the table is swept to
//   zero one entry a cycle; s_axis_tready stays low until the sweep is done.
//   stall: a result waits in the output register while m_axis_tready is
//   low; one more item is held in the table stage, then s_axis_tready drops.
//   skipped items (inactive box, equal ids) still give a result, event none.
// ----------------------------------------------------------------------------
module aabb_contact_event_tracker_core
    import acet_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_id, right_id, left_cx, left_cy, left_w, left_h,
    // right_cx, right_cy, right_w, right_h, 4 bits zero fill
    input  logic [143:0] s_axis_tdata,
    // left_active, right_active
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // overlap_x, overlap_y, 6 bits zero fill
    output logic [39:0]  m_axis_tdata,
    // contact_event
    output logic [1:0]   m_axis_tuser
);

    // input field unpacking
    logic        [ID_W-1:0]    left_id;
    logic        [ID_W-1:0]    right_id;
    logic                      left_active;
    logic                      right_active;
    logic signed [COORD_W-1:0] left_cx;
    logic signed [COORD_W-1:0] left_cy;
    logic        [COORD_W-1:0] left_w;
    logic        [COORD_W-1:0] left_h;
    logic signed [COORD_W-1:0] right_cx;
    logic signed [COORD_W-1:0] right_cy;
    logic        [COORD_W-1:0] right_w;
    logic        [COORD_W-1:0] right_h;

    assign left_id      = s_axis_tdata[5:0];
    assign right_id     = s_axis_tdata[11:6];
    assign left_cx      = $signed(s_axis_tdata[27:12]);
    assign left_cy      = $signed(s_axis_tdata[43:28]);
    assign left_w       = s_axis_tdata[59:44];
    assign left_h       = s_axis_tdata[75:60];
    assign right_cx     = $signed(s_axis_tdata[91:76]);
    assign right_cy     = $signed(s_axis_tdata[107:92]);
    assign right_w      = s_axis_tdata[123:108];
    assign right_h      = s_axis_tdata[139:124];
    assign left_active  = s_axis_tuser[0];
    assign right_active = s_axis_tuser[1];

    // handshake and stage control
    logic             mem_ready;
    logic             in_accept;
    logic             s1_adv;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_skip_reg;
    logic             s1_skip_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [IDX_W-1:0] idx_in;
    logic             skip_in;
    logic             fwd_hit_reg;
    logic             fwd_hit_next;
    logic             fwd_bit_reg;
    logic             fwd_bit_next;

    // table stage
    logic               mem_rd_data;
    acet_wr_t           mem_wr;
    logic               hit_x;
    logic               hit_y;
    logic [DEPTH_W-1:0] depth_x;
    logic [DEPTH_W-1:0] depth_y;
    logic               old_contact;
    logic               touch;
    logic [EV_W-1:0]    ev;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [EV_W-1:0]    out_event_reg;
    logic [DEPTH_W-1:0] out_ovx_reg;
    logic [DEPTH_W-1:0] out_ovy_reg;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = mem_ready && (!s1_valid_reg || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // pair index and skip test
    assign idx_in  = IDX_W'(int'(left_id) * NUM_COLLIDERS + int'(right_id));
    assign skip_in = !left_active || !right_active || (left_id == right_id)
                     || (int'(left_id) >= NUM_COLLIDERS)
                     || (int'(right_id) >= NUM_COLLIDERS);

    acet_axis u_axis_x
    (
        .clk   (clk),
        .load  (in_accept),
        .lc    (left_cx),
        .ls    (left_w),
        .rc    (right_cx),
        .rs    (right_w),
        .hit   (hit_x),
        .depth (depth_x)
    );

    acet_axis u_axis_y
    (
        .clk   (clk),
        .load  (in_accept),
        .lc    (left_cy),
        .ls    (left_h),
        .rc    (right_cy),
        .rs    (right_h),
        .hit   (hit_y),
        .depth (depth_y)
    );

    acet_pair_mem u_pair_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (idx_in),
        .rd_data (mem_rd_data),
        .wr      (mem_wr),
        .ready   (mem_ready)
    );

    // a write to the same pair on the read edge is not seen by the ram read
    assign old_contact = fwd_hit_reg ? fwd_bit_reg : mem_rd_data;
    assign touch       = hit_x && hit_y;

    always_comb
    begin
        priority if (s1_skip_reg)
        begin
            ev = EV_NONE;
        end
        else if (touch)
        begin
            ev = old_contact ? EV_STAY : EV_ENTER;
        end
        else
        begin
            ev = old_contact ? EV_EXIT : EV_NONE;
        end
    end

    // write back the new contact bit for every tested pair
    always_comb
    begin
        mem_wr.en   = s1_adv && !s1_skip_reg;
        mem_wr.addr = s1_idx_reg;
        mem_wr.data = touch;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_skip_next  = s1_skip_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_bit_next  = fwd_bit_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_skip_next  = skip_in;
            fwd_hit_next  = mem_wr.en && (mem_wr.addr == idx_in);
            fwd_bit_next  = mem_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_skip_reg <= s1_skip_next;
        fwd_bit_reg <= fwd_bit_next;
        if (in_accept)
        begin
            s1_idx_reg <= idx_in;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_event_reg <= ev;
            out_ovx_reg   <= (touch && !s1_skip_reg) ? depth_x : '0;
            out_ovy_reg   <= (touch && !s1_skip_reg) ? depth_y : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tdata  = {6'b0, out_ovy_reg, out_ovx_reg};

    // checks

    // enter and stay always come with nonzero depths
    a_touch_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg == EV_ENTER || out_event_reg == EV_STAY)
        |-> (out_ovx_reg != '0) && (out_ovy_reg != '0))
        else $error("contact event without overlap depth");

    // none and exit carry zero depths
    a_free_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg == EV_NONE || out_event_reg == EV_EXIT)
        |-> (out_ovx_reg == '0) && (out_ovy_reg == '0))
        else $error("depth given without contact");

    // nothing enters the table stage during the clearing sweep
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !mem_ready |-> !s1_valid_reg && !mem_wr.en)
        else $error("table access during clearing sweep");

    // an item leaving the table stage shows up on the output
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result lost between table stage and output");

    // a same-pair write while an item is taken is always forwarded
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && mem_wr.en && (mem_wr.addr == idx_in) |=> fwd_hit_reg)
        else $error("same-pair write not forwarded");

endmodule

// File: verif/contact_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_event_checker
// watches both streams of the contact tracker, predicts each result from its
// own copy of the per-pair contact table and compares in order
// ----------------------------------------------------------------------------
module contact_event_checker
    import acet_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [EV_W-1:0]    contact_event;
        logic [DEPTH_W-1:0] overlap_x;
        logic [DEPTH_W-1:0] overlap_y;
    } contact_result_t;

    contact_result_t expected_contacts[$];
    logic            contact_bits [PAIR_DEPTH];
    int              result_count;

    // doubled penetration depth on one axis, hit flag in the top bit
    function automatic logic [DEPTH_W:0] axis_overlap(
        input logic signed [COORD_W-1:0] lc,
        input logic [COORD_W-1:0]        ls,
        input logic signed [COORD_W-1:0] rc,
        input logic [COORD_W-1:0]        rs
    );
        int                 offset;
        logic [DEPTH_W-1:0] twice;
        logic [DEPTH_W-1:0] span;
        offset = int'(rc) - int'(lc);
        if (offset < 0)
            offset = -offset;
        twice = DEPTH_W'(offset * 2);
        span  = {1'b0, ls} + {1'b0, rs};
        if (twice < span)
            return {1'b1, span - twice};
        return '0;
    endfunction

    // result of one pair item; updates the contact table
    function automatic contact_result_t predict_contact(
        input logic [143:0] d,
        input logic [1:0]   u
    );
        contact_result_t    r;
        logic [ID_W-1:0]    lid;
        logic [ID_W-1:0]    rid;
        logic [DEPTH_W:0]   ax;
        logic [DEPTH_W:0]   ay;
        int                 idx;
        lid = d[5:0];
        rid = d[11:6];
        r   = '0;
        r.contact_event = EV_NONE;
        // inactive box, same id or id out of range: skipped, table untouched
        if (!u[0] || !u[1] || lid == rid
            || int'(lid) >= NUM_COLLIDERS || int'(rid) >= NUM_COLLIDERS)
            return r;
        idx = int'(lid) * NUM_COLLIDERS + int'(rid);
        ax  = axis_overlap(d[27:12], d[59:44], d[91:76], d[123:108]);
        ay  = axis_overlap(d[43:28], d[75:60], d[107:92], d[139:124]);
        if (ax[DEPTH_W] && ay[DEPTH_W])
        begin
            r.contact_event   = contact_bits[idx] ? EV_STAY : EV_ENTER;
            r.overlap_x       = ax[DEPTH_W-1:0];
            r.overlap_y       = ay[DEPTH_W-1:0];
            contact_bits[idx] = 1'b1;
        end
        else if (contact_bits[idx])
        begin
            r.contact_event   = EV_EXIT;
            contact_bits[idx] = 1'b0;
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        contact_result_t want;
        contact_result_t got;
        if (!rst_n)
        begin
            foreach (contact_bits[i])
                contact_bits[i] = 1'b0;
            expected_contacts.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_contacts.push_back(predict_contact(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                got.contact_event = m_tuser;
                got.overlap_x     = m_tdata[16:0];
                got.overlap_y     = m_tdata[33:17];
                if (expected_contacts.size() == 0)
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           result_count));
                else
                begin
                    want = expected_contacts.pop_front();
                    if (got.contact_event != want.contact_event
                        || got.overlap_x != want.overlap_x
                        || got.overlap_y != want.overlap_y)
                        note_failure($sformatf(
                            "result %0d mismatch: event %0d/%0d x %0d/%0d y %0d/%0d (exp/got)",
                            result_count, want.contact_event, got.contact_event,
                            want.overlap_x, got.overlap_x, want.overlap_y, got.overlap_y));
                end
                result_count++;
            end
            pending = expected_contacts.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the box contact event tracker: directed pairs for
// enter, stay, exit, skips and edge cases, then bursts of random pair items
// against a randomly stalling receiver; the checker does all comparing
// ----------------------------------------------------------------------------
module tb;
    import acet_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;  // includes the table sweep after reset
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_AT      = 150;
    localparam int PAUSE_AT     = 320;

    // active flags as they travel in tuser: right_active, left_active
    localparam logic [1:0] BOTH_ON   = 2'b11;
    localparam logic [1:0] LEFT_OFF  = 2'b10;
    localparam logic [1:0] RIGHT_OFF = 2'b01;
    localparam logic [1:0] BOTH_OFF  = 2'b00;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    int fail_count;
    int pending;
    int hold_requests = 0;
    int holds_done    = 0;
    int cycles        = 0;

    aabb_contact_event_tracker_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    contact_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offer one pair item at the falling edge and hold it until taken;
    // tvalid is left high so a following item in the burst goes straight on
    task automatic send_boxes(
        input logic [ID_W-1:0]    lid,
        input logic [ID_W-1:0]    rid,
        input logic [1:0]         act,
        input logic [COORD_W-1:0] lcx,
        input logic [COORD_W-1:0] lcy,
        input logic [COORD_W-1:0] lw,
        input logic [COORD_W-1:0] lh,
        input logic [COORD_W-1:0] rcx,
        input logic [COORD_W-1:0] rcy,
        input logic [COORD_W-1:0] rw,
        input logic [COORD_W-1:0] rh
    );
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        // fields listed from the top bit down, starting with 4 bits zero fill
        s_axis_tdata  = {4'b0, rh, rw, rcy, rcx, lh, lw, lcy, lcx, rid, lid};
        s_axis_tuser  = act;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // mostly boxes near each other among a few ids so pairs come back and
    // walk through enter, stay and exit; the rest is unconstrained noise
    task automatic send_random_pair();
        logic [ID_W-1:0]    lid;
        logic [ID_W-1:0]    rid;
        logic [1:0]         act;
        logic [COORD_W-1:0] lcx;
        logic [COORD_W-1:0] lcy;
        logic [COORD_W-1:0] rcx;
        logic [COORD_W-1:0] rcy;
        logic [COORD_W-1:0] sz [4];
        int                 dx;
        int                 dy;
        if ($urandom_range(0, 99) < 85)
        begin
            lid    = ID_W'($urandom_range(0, 7));
            rid    = ID_W'($urandom_range(0, 7));
            act[0] = ($urandom_range(0, 19) != 0);
            act[1] = ($urandom_range(0, 19) != 0);
            lcx    = COORD_W'($urandom);
            lcy    = COORD_W'($urandom);
            dx     = int'($urandom_range(0, 8191)) - 4096;
            dy     = int'($urandom_range(0, 8191)) - 4096;
            rcx    = lcx + COORD_W'(dx);
            rcy    = lcy + COORD_W'(dy);
            foreach (sz[i])
                sz[i] = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom)
                                                    : COORD_W'($urandom_range(0, 8191));
        end
        else
        begin
            lid = ID_W'($urandom);
            rid = ID_W'($urandom);
            act = 2'($urandom);
            lcx = COORD_W'($urandom);
            lcy = COORD_W'($urandom);
            rcx = COORD_W'($urandom);
            rcy = COORD_W'($urandom);
            foreach (sz[i])
                sz[i] = COORD_W'($urandom);
        end
        send_boxes(lid, rid, act, lcx, lcy, sz[0], sz[1], rcx, rcy, sz[2], sz[3]);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // receiver: segments of always ready, coin flip or mostly stalled, and
    // one long hold-off on request so the block backs up into its input
    initial
    begin : receiver
        int mode;
        int seg;
        m_axis_tready = 1'b0;
        forever
        begin
            if (hold_requests != holds_done)
            begin
                holds_done++;
                repeat (HOLD_CYCLES) @(negedge clk) m_axis_tready = 1'b0;
            end
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(16, 64);
            repeat (seg)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // run limit, counted in clock cycles
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int  sent;
        int  burst;
        int  gap;
        bit  paused;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = BOTH_OFF;
        sent          = 0;
        paused        = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // enter, stay, the reversed pair on its own, exit, then none
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 0, 0, 16, 16);
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 4, 4, 16, 16);
        send_boxes(2, 1, BOTH_ON, 0, 0, 16, 16, 0, 0, 16, 16);
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 100, 0, 16, 16);
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 100, 0, 16, 16);
        // inactive left box on an overlap: skipped, so next overlap enters
        send_boxes(1, 2, LEFT_OFF, 0, 0, 16, 16, 0, 0, 16, 16);
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 0, 0, 16, 16);
        // inactive right box while apart: contact kept, so overlap stays
        send_boxes(1, 2, RIGHT_OFF, 0, 0, 16, 16, 500, 500, 16, 16);
        send_boxes(1, 2, BOTH_ON, 0, 0, 16, 16, 0, 0, 16, 16);
        send_boxes(1, 2, BOTH_OFF, 0, 0, 16, 16, 900, 0, 16, 16);
        // same id on both sides
        send_boxes(5, 5, BOTH_ON, 0, 0, 16, 16, 0, 0, 16, 16);
        // edges touching in x is no overlap, one step inside enters,
        // then edges touching in y exits
        send_boxes(3, 4, BOTH_ON, 0, 0, 16, 16, 16, 0, 16, 16);
        send_boxes(3, 4, BOTH_ON, 0, 0, 16, 16, 15, 0, 16, 16);
        send_boxes(3, 4, BOTH_ON, 0, 0, 16, 16, 0, 16, 16, 16);
        // extreme centres and sizes
        send_boxes(0, 63, BOTH_ON, 16'h8001, 16'h8000, 16'hFFFF, 16'hFFFF,
                   16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_boxes(0, 63, BOTH_ON, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                   16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_boxes(63, 0, BOTH_ON, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                   16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        // zero sizes never overlap, even on the same centre
        send_boxes(63, 0, BOTH_ON, 16'h7FFF, 16'h7FFF, 0, 0, 16'h7FFF, 16'h7FFF, 0, 0);
        send_boxes(62, 61, BOTH_ON, 16'h5555, 16'hAAAA, 16'h2AAA, 16'h5555,
                   16'h5555, 16'hAAAA, 16'h2AAA, 16'h5555);
        drain_results();

        // random bursts; a gap of zero runs straight into the next burst
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                send_random_pair();
                sent++;
                if (sent == HOLD_AT)
                    hold_requests <= hold_requests + 1;
            end
            if (sent >= PAUSE_AT && !paused)
            begin
                paused = 1'b1;
                drain_results();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk) s_axis_tvalid = 1'b0;
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
